>>> rtl/core/bpp_pkg.sv
// Package with shared types and constants for the bitmap pixel row packer.
`timescale 1ns / 1ps

package bpp_pkg;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam int ROW_W_W    = 13;
    localparam int BYTE_W     = 8;
    localparam int MAX_BYTES  = 7;   // four pixel bytes plus three pad bytes
    localparam int CNT_W      = 3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH = 1'b1;

    // Output modes
    typedef enum logic [2:0] {
        MODE_BGRA      = 3'd0,
        MODE_BGR       = 3'd1,
        MODE_GREY_WGT  = 3'd2,
        MODE_GREY_AVG  = 3'd3,
        MODE_BGR_INV   = 3'd4
    } mode_t;

    // Luma weights 0.21 / 0.72 / 0.07 in unsigned Q0.16
    localparam logic [15:0] W_RED   = 16'd13763;
    localparam logic [15:0] W_GREEN = 16'd47186;
    localparam logic [15:0] W_BLUE  = 16'd4588;

    // floor(x / 3) == (x * DIV3_MUL) >> DIV3_SHIFT for x <= 765
    localparam logic [11:0] DIV3_MUL   = 12'd2731;
    localparam int          DIV3_SHIFT = 13;

    localparam logic [BYTE_W-1:0] BYTE_MAX = 8'd255;

endpackage

>>> rtl/core/bitmap_pixel_row_packer.sv
// Top level of the bitmap pixel row packer: pixel register, byte builder and byte serializer.
`timescale 1ns / 1ps

// Takes one RGBA pixel per transaction and emits its bytes in bitmap
// pixel-array order, one byte per output transaction. Mode selects BGRA
// (4 bytes), BGR (3), weighted grey (1), average grey (1) or inverted BGR (3);
// unused mode codes drop the pixel with no output. After the last pixel of a
// row (row_width pixels, 0 read as 1, clamped to MAX_WIDTH) zero pad bytes are
// appended so each row is a multiple of four bytes, in every mode. The output
// side moves one byte per cycle while byte_stall is low, so a pixel occupies
// the output for its byte count plus any pad: 1 to 6 bytes, always 4 in BGRA
// mode (never padded). The serializer that shifts out those bytes sets the
// rate. A pixel register, a byte buffer and an output register are chained,
// so the next pixel is taken while the previous one is still being shifted
// out; the first byte passes through all three before it is offered.
// Configuration writes are expected only while the block is idle;
// cfg_ready is always high.
module bitmap_pixel_row_packer #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,

    // configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bpp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bpp_pkg::CFG_DATA_W-1:0] cfg_data,

    // pixel channel
    input  logic                          pixel_valid,
    output logic                          pixel_stall,
    input  logic [7:0]                    red,
    input  logic [7:0]                    green,
    input  logic [7:0]                    blue,
    input  logic [7:0]                    alpha,

    // byte channel
    output logic                          byte_valid,
    input  logic                          byte_stall,
    output logic [7:0]                    out_byte,
    output logic                          row_end,
    output logic                          last_of_run
);

    import bpp_pkg::*;

    // Column counter width and compare width (covers both row_width and MAX_WIDTH)
    localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CMPW = ((CW > ROW_W_W) ? CW : ROW_W_W) + 1;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    mode_t                mode_reg;
    logic [ROW_W_W-1:0]   row_width_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_BGRA;
            row_width_reg <= ROW_W_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MODE:      mode_reg      <= mode_t'(cfg_data[2:0]);
                CFG_ROW_WIDTH: row_width_reg <= cfg_data[ROW_W_W-1:0];
                default:       ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Flow control: output reg <- byte buffer <- pixel reg
    // ---------------------------------------------------------------
    logic                 pix_valid_reg;
    logic [7:0]           r_reg, g_reg, b_reg, a_reg;

    logic                 buf_valid_reg;
    logic [BYTE_W-1:0]    buf_bytes_reg [MAX_BYTES];
    logic [BYTE_W-1:0]    buf_bytes_next [MAX_BYTES];
    logic [CNT_W-1:0]     buf_rem_reg;
    logic                 buf_ends_reg;

    logic                 out_valid_reg;
    logic [BYTE_W-1:0]    out_byte_reg;
    logic                 row_end_reg;
    logic                 last_reg;

    logic [CW-1:0]        col_reg;
    logic [CW-1:0]        col_next;

    logic                 out_free;
    logic                 buf_emit;
    logic                 buf_last;
    logic                 buf_free;
    logic                 pix_move;
    logic                 pix_free;

    assign out_free    = !out_valid_reg || !byte_stall;
    assign buf_emit    = buf_valid_reg && out_free;
    assign buf_last    = (buf_rem_reg == CNT_W'(1));
    assign buf_free    = !buf_valid_reg || (out_free && buf_last);
    assign pix_move    = pix_valid_reg && buf_free;
    assign pix_free    = !pix_valid_reg || buf_free;
    assign pixel_stall = !pix_free;

    // ---------------------------------------------------------------
    // Pixel register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pix_valid_reg <= 1'b0;
        else if (pix_free)
            pix_valid_reg <= pixel_valid;
    end

    always_ff @(posedge clk)
    begin
        if (pix_free && pixel_valid)
        begin
            r_reg <= red;
            g_reg <= green;
            b_reg <= blue;
            a_reg <= alpha;
        end
    end

    // ---------------------------------------------------------------
    // Byte builder (combinational from the pixel register)
    // ---------------------------------------------------------------
    logic [23:0]          wsum;
    logic [9:0]           sum3;
    logic [21:0]          avg_prod;
    logic [7:0]           grey_w;
    logic [7:0]           grey_a;
    logic [BYTE_W-1:0]    bytes_new [MAX_BYTES];
    logic [CNT_W-1:0]     px_bytes;
    logic                 mode_ok;
    logic [1:0]           row_lo;      // (w * px_bytes) mod 4
    logic [1:0]           pad;
    logic [CNT_W-1:0]     n_new;
    logic [CMPW-1:0]      rw_ext;
    logic [CMPW-1:0]      w_eff;
    logic [CMPW-1:0]      col_inc;
    logic                 ends_row;

    assign wsum = 24'(r_reg) * 24'(W_RED) + 24'(g_reg) * 24'(W_GREEN)
                + 24'(b_reg) * 24'(W_BLUE);
    // weights sum to 65537, so the top byte never exceeds 255
    assign grey_w   = wsum[23:16];
    assign sum3     = 10'(r_reg) + 10'(g_reg) + 10'(b_reg);
    assign avg_prod = 22'(sum3) * 22'(DIV3_MUL);
    assign grey_a   = avg_prod[DIV3_SHIFT+7:DIV3_SHIFT];

    always_comb
    begin
        rw_ext = CMPW'(row_width_reg);
        if (rw_ext == '0)
            w_eff = CMPW'(1);
        else if (rw_ext > CMPW'(MAX_WIDTH))
            w_eff = CMPW'(MAX_WIDTH);
        else
            w_eff = rw_ext;
        col_inc  = CMPW'(col_reg) + CMPW'(1);
        ends_row = (col_inc >= w_eff);
    end

    always_comb
    begin
        for (int k = 0; k < MAX_BYTES; k++)
            bytes_new[k] = '0;
        px_bytes = CNT_W'(1);
        mode_ok  = 1'b1;
        row_lo   = w_eff[1:0];
        case (mode_reg)
            MODE_BGRA:
            begin
                bytes_new[0] = b_reg;
                bytes_new[1] = g_reg;
                bytes_new[2] = r_reg;
                bytes_new[3] = a_reg;
                px_bytes     = CNT_W'(4);
                row_lo       = 2'd0;
            end
            MODE_BGR:
            begin
                bytes_new[0] = b_reg;
                bytes_new[1] = g_reg;
                bytes_new[2] = r_reg;
                px_bytes     = CNT_W'(3);
                row_lo       = 2'(w_eff[1:0] * 2'd3);
            end
            MODE_GREY_WGT:
            begin
                bytes_new[0] = grey_w;
            end
            MODE_GREY_AVG:
            begin
                bytes_new[0] = grey_a;
            end
            MODE_BGR_INV:
            begin
                bytes_new[0] = BYTE_MAX - b_reg;
                bytes_new[1] = BYTE_MAX - g_reg;
                bytes_new[2] = BYTE_MAX - r_reg;
                px_bytes     = CNT_W'(3);
                row_lo       = 2'(w_eff[1:0] * 2'd3);
            end
            default:
            begin
                mode_ok = 1'b0;
            end
        endcase
        pad   = ends_row ? 2'(3'd4 - 3'(row_lo)) : 2'd0;
        n_new = px_bytes + CNT_W'(pad);
    end

    // ---------------------------------------------------------------
    // Column counter (advances as a pixel enters the byte buffer)
    // ---------------------------------------------------------------
    assign col_next = ends_row ? '0 : CW'(col_inc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            col_reg <= '0;
        else if (pix_move && mode_ok)
            col_reg <= col_next;
    end

    // ---------------------------------------------------------------
    // Byte buffer: shifts one byte toward slot 0 per emission
    // ---------------------------------------------------------------
    always_comb
    begin
        for (int k = 0; k < MAX_BYTES; k++)
            buf_bytes_next[k] = buf_bytes_reg[k];
        if (pix_move && mode_ok)
        begin
            for (int k = 0; k < MAX_BYTES; k++)
                buf_bytes_next[k] = bytes_new[k];
        end
        else if (buf_emit)
        begin
            for (int k = 0; k < MAX_BYTES - 1; k++)
                buf_bytes_next[k] = buf_bytes_reg[k+1];
            buf_bytes_next[MAX_BYTES-1] = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_BYTES; k++)
            buf_bytes_reg[k] <= buf_bytes_next[k];
        if (pix_move && mode_ok)
            buf_ends_reg <= ends_row;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_valid_reg <= 1'b0;
            buf_rem_reg   <= '0;
        end
        else if (pix_move && mode_ok)
        begin
            buf_valid_reg <= 1'b1;
            buf_rem_reg   <= n_new;
        end
        else if (buf_emit)
        begin
            buf_valid_reg <= !buf_last;
            buf_rem_reg   <= buf_rem_reg - CNT_W'(1);
        end
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= buf_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (buf_emit)
        begin
            out_byte_reg <= buf_bytes_reg[0];
            last_reg     <= buf_last;
            row_end_reg  <= buf_last && buf_ends_reg;
        end
    end

    assign byte_valid  = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign row_end     = row_end_reg;
    assign last_of_run = last_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_buf_rem_nonzero: assert property (
        @(posedge clk) disable iff (!rst_n)
        buf_valid_reg |-> (buf_rem_reg != '0))
        else $error("byte buffer valid with no bytes left");

    a_row_end_is_last: assert property (
        @(posedge clk) disable iff (!rst_n)
        byte_valid |-> (!row_end || last_of_run))
        else $error("row end flagged on a byte that is not the last of its pixel");

    a_drop_unused_mode: assert property (
        @(posedge clk) disable iff (!rst_n)
        (pix_move && !mode_ok) |=> !buf_valid_reg)
        else $error("pixel in unused mode produced bytes");

    a_col_hold_on_drop: assert property (
        @(posedge clk) disable iff (!rst_n)
        (pix_move && !mode_ok) |=> (col_reg == $past(col_reg)))
        else $error("column count moved on a dropped pixel");

endmodule
